// ----- src/tsct_pkg.sv -----
`timescale 1ns / 1ps
package tsct_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int MAX_RES   = 8;

  localparam logic [31:0] ISN    = 32'h1000_0000;
  localparam logic [15:0] WINDOW = 16'd1460;

  localparam logic [1:0] CFG_SERVER_PORT = 2'd0;
  localparam logic [1:0] CFG_RETRY_TICKS = 2'd1;
  localparam logic [1:0] CFG_MAX_RETRIES = 2'd2;

  localparam logic [1:0] CODE_NONE    = 2'd0;
  localparam logic [1:0] CODE_HANDLED = 2'd1;
  localparam logic [1:0] CODE_DATA    = 2'd2;

  localparam logic [2:0] RPL_NONE   = 3'd0;
  localparam logic [2:0] RPL_SYNACK = 3'd1;
  localparam logic [2:0] RPL_ACK    = 3'd2;
  localparam logic [2:0] RPL_FINACK = 3'd3;
  localparam logic [2:0] RPL_RSTACK = 3'd4;

  localparam logic [1:0] PH_CLOSED  = 2'd0;
  localparam logic [1:0] PH_SYNRCVD = 2'd1;
  localparam logic [1:0] PH_EST     = 2'd2;
  localparam logic [1:0] PH_LASTACK = 2'd3;

  // bit positions in the flag byte
  localparam int FB_FIN = 0;
  localparam int FB_SYN = 1;
  localparam int FB_RST = 2;
  localparam int FB_ACK = 4;

  typedef struct packed {
    logic        kind;
    logic [31:0] now;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [15:0] target_port;
    logic [31:0] seq_in;
    logic [31:0] ack_in;
    logic [7:0]  flags_in;
    logic [3:0]  header_words;
    logic [15:0] ip_total;
    logic [5:0]  ip_hdr_bytes;
  } item_t;

  typedef struct packed {
    logic [1:0]  code;
    logic [2:0]  reply;
    logic [2:0]  slot_out;
    logic [31:0] dest_ip;
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [31:0] seq_out;
    logic [31:0] ack_out;
    logic [15:0] window_out;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] own_seq;
    logic [31:0] peer_seq;
    logic [3:0]  retries;
    logic [31:0] deadline;
  } slot_rec_t;

endpackage

// ----- src/tsct_if.sv -----
`timescale 1ns / 1ps
interface tsct_in_if;
  logic valid;
  logic ready;
  tsct_pkg::item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsct_out_if;
  logic valid;
  logic ready;
  tsct_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/tsct_ram.sv -----
`timescale 1ns / 1ps
module tsct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/tcp_server_connection_table.sv -----
`timescale 1ns / 1ps
// Segment: a search step per slot (address out, then compare of the registered read), then
//   an update of the slot, a load of the result and a return to idle; search ends early
//   on a hit or another port; the load waits only while the result register is held.
// Tick: address out and deadline test per slot over the whole table, a flush of the last
//   SYN-ACK and back to idle; stalls only while the result register is held by the sink.
// Reset (rst, synchronous): all slots closed at once via per-slot live bits,
//   registers back to port 80, 1000 ticks, 3 retries; no clearing pass.
module tcp_server_connection_table #(
  parameter int SLOTS = tsct_pkg::SLOTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  tsct_in_if.sink      req,
  tsct_out_if.source   rsp,
  input  logic         cfg_en,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import tsct_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SRD   = 3'd1;  // search: address out
  localparam logic [2:0] ST_SCHK  = 3'd2;  // search: compare entry
  localparam logic [2:0] ST_SPROC = 3'd3;  // segment: update slot
  localparam logic [2:0] ST_SPUSH = 3'd4;  // segment: load result
  localparam logic [2:0] ST_TRD   = 3'd5;  // tick scan: address out
  localparam logic [2:0] ST_TCHK  = 3'd6;  // tick scan: test deadline
  localparam logic [2:0] ST_TEND  = 3'd7;  // tick: flush held SYN-ACK

  // control
  logic [2:0]      state;
  logic [IW-1:0]   idx;
  logic            found;
  logic [IW-1:0]   found_idx;
  logic            have_free;
  logic [IW-1:0]   free_idx;
  logic [3:0]      n;
  logic            pend;
  logic [SLOTS-1:0] live;
  logic            out_valid;
  logic            out_load;

  // configuration
  logic [15:0]     server_port;
  logic [31:0]     retry_ticks;
  logic [3:0]      max_retries;

  // payload
  item_t           cur;
  logic [15:0]     dlen;
  slot_rec_t       rec;
  result_t         res;
  result_t         pend_res;
  result_t         out_data;
  result_t         out_next;

  // memory port
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  slot_rec_t       wr_data;
  slot_rec_t       rdata;

  tsct_ram #(.WIDTH($bits(slot_rec_t)), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (idx),
    .rdata (rdata)
  );

  function automatic result_t mk_res(logic [1:0] c, logic [2:0] r, logic [2:0] s,
                                     logic [31:0] ip, logic [15:0] fp, logic [15:0] tp,
                                     logic [31:0] sq, logic [31:0] ak, logic [15:0] w);
    result_t o;
    o.code       = c;
    o.reply      = r;
    o.slot_out   = s;
    o.dest_ip    = ip;
    o.from_port  = fp;
    o.to_port    = tp;
    o.seq_out    = sq;
    o.ack_out    = ak;
    o.window_out = w;
    o.last       = 1'b1;
    return o;
  endfunction

  // payload length, floored at zero: a borrow shows in bit 16
  logic [16:0] len_diff;
  assign len_diff = {1'b0, req.data.ip_total} - 17'(req.data.ip_hdr_bytes)
                    - 17'({req.data.header_words, 2'b00});

  logic out_free;
  assign out_free = !out_valid || rsp.ready;

  // entry under the scan; a slot that is not live reads as free
  logic s_closed, s_match;
  assign s_closed = !live[idx];
  assign s_match  = live[idx] && (rdata.addr == cur.peer_ip) &&
                    (rdata.port == cur.peer_port);

  // tick tests
  logic      due, retx, expire, stall;
  slot_rec_t trec;
  result_t   tres;
  assign due    = live[idx] && (rdata.phase == PH_SYNRCVD) && (cur.now > rdata.deadline);
  assign retx   = due && (rdata.retries < max_retries) && (n < 4'(MAX_RES));
  assign expire = due && !(rdata.retries < max_retries);
  assign stall  = retx && pend && !out_free;

  always_comb begin
    trec          = rdata;
    trec.retries  = rdata.retries + 4'd1;
    trec.deadline = cur.now + retry_ticks;
    tres = mk_res(CODE_HANDLED, RPL_SYNACK, 3'(idx), trec.addr, server_port, trec.port,
                  trec.own_seq, trec.peer_seq + 32'd1, WINDOW);
  end

  // segment update
  logic      p_we, p_set, p_clr, go_est;
  logic [IW-1:0] p_addr;
  slot_rec_t p_rec;
  result_t   p_res;

  always_comb begin
    p_we   = 1'b0;
    p_set  = 1'b0;
    p_clr  = 1'b0;
    p_addr = found ? found_idx : free_idx;
    p_rec  = rec;
    p_res  = mk_res(CODE_NONE, RPL_NONE, 3'd0, 32'd0, 16'd0, 16'd0, 32'd0, 32'd0, 16'd0);
    go_est = 1'b0;
    if (!found) begin
      if (cur.flags_in[FB_SYN]) begin
        if (have_free) begin
          p_rec.phase    = PH_SYNRCVD;
          p_rec.addr     = cur.peer_ip;
          p_rec.port     = cur.peer_port;
          p_rec.own_seq  = ISN;
          p_rec.peer_seq = cur.seq_in;
          p_rec.retries  = 4'd0;
          p_rec.deadline = cur.now + retry_ticks;
          p_we  = 1'b1;
          p_set = 1'b1;
          p_res = mk_res(CODE_HANDLED, RPL_SYNACK, 3'(free_idx), cur.peer_ip, server_port,
                         cur.peer_port, ISN, cur.seq_in + 32'd1, WINDOW);
        end
      end else begin
        // unknown peer: reset it, even if it sent RST itself
        p_res = mk_res(CODE_HANDLED, RPL_RSTACK, 3'd0, cur.peer_ip, cur.target_port,
                       cur.peer_port, 32'd0, cur.seq_in + 32'd1, 16'd0);
      end
    end else if (cur.flags_in[FB_RST]) begin
      p_clr = 1'b1;
      p_res = mk_res(CODE_HANDLED, RPL_NONE, 3'(found_idx), 32'd0, 16'd0, 16'd0,
                     32'd0, 32'd0, 16'd0);
    end else begin
      if (rec.phase == PH_SYNRCVD && cur.flags_in[FB_ACK]) begin
        p_rec.phase   = PH_EST;
        p_rec.own_seq = rec.own_seq + 32'd1;
        p_we  = 1'b1;
        p_res = mk_res(CODE_HANDLED, RPL_NONE, 3'(found_idx), 32'd0, 16'd0, 16'd0,
                       32'd0, 32'd0, 16'd0);
        go_est = (dlen != 16'd0);
      end else if (rec.phase == PH_EST) begin
        go_est = 1'b1;
      end else if (rec.phase == PH_LASTACK) begin
        p_clr = cur.flags_in[FB_ACK];
        p_res = mk_res(CODE_HANDLED, RPL_NONE, 3'(found_idx), 32'd0, 16'd0, 16'd0,
                       32'd0, 32'd0, 16'd0);
      end
      if (go_est) begin
        if (cur.flags_in[FB_FIN]) begin
          p_rec.phase    = PH_LASTACK;
          p_rec.peer_seq = cur.seq_in;
          p_we  = 1'b1;
          p_res = mk_res(CODE_HANDLED, RPL_FINACK, 3'(found_idx), rec.addr, server_port,
                         rec.port, p_rec.own_seq, cur.seq_in + 32'd1, WINDOW);
        end else if (dlen != 16'd0) begin
          p_rec.peer_seq = cur.seq_in;
          p_we  = 1'b1;
          p_res = mk_res(CODE_DATA, RPL_ACK, 3'(found_idx), rec.addr, server_port,
                         rec.port, p_rec.own_seq, cur.seq_in + 32'(dlen), WINDOW);
        end else begin
          p_res = mk_res(CODE_HANDLED, RPL_NONE, 3'(found_idx), 32'd0, 16'd0, 16'd0,
                         32'd0, 32'd0, 16'd0);
        end
      end
    end
  end

  // memory write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = trec;
    if (state == ST_SPROC) begin
      wr_en   = p_we;
      wr_addr = p_addr;
      wr_data = p_rec;
    end else if (state == ST_TCHK) begin
      wr_en = retx && !stall;
    end
  end

  // result register load: segment result, an earlier SYN-ACK that is not last,
  // or the final SYN-ACK of a tick
  always_comb begin
    out_load = 1'b0;
    out_next = res;
    if (state == ST_SPUSH) begin
      out_load = out_free;
    end else if (state == ST_TCHK) begin
      out_load      = retx && pend && !stall;
      out_next      = pend_res;
      out_next.last = 1'b0;
    end else if (state == ST_TEND) begin
      out_load      = pend && out_free;
      out_next      = pend_res;
      out_next.last = 1'b1;
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      server_port <= 16'd80;
      retry_ticks <= 32'd1000;
      max_retries <= 4'd3;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_SERVER_PORT: server_port <= cfg_data[15:0];
        CFG_RETRY_TICKS: retry_ticks <= cfg_data;
        CFG_MAX_RETRIES: max_retries <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_data  <= out_next;
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx       <= '0;
      found     <= 1'b0;
      have_free <= 1'b0;
      n         <= 4'd0;
      pend      <= 1'b0;
      live      <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            cur       <= req.data;
            dlen      <= len_diff[16] ? 16'd0 : len_diff[15:0];
            idx       <= '0;
            found     <= 1'b0;
            have_free <= 1'b0;
            n         <= 4'd0;
            pend      <= 1'b0;
            if (req.data.kind) begin
              state <= ST_TRD;
            end else if (req.data.target_port != server_port) begin
              res   <= mk_res(CODE_NONE, RPL_NONE, 3'd0, 32'd0, 16'd0, 16'd0,
                              32'd0, 32'd0, 16'd0);
              state <= ST_SPUSH;
            end else begin
              state <= ST_SRD;
            end
          end
        end
        ST_SRD: state <= ST_SCHK;
        ST_SCHK: begin
          if (s_match) begin
            found     <= 1'b1;
            found_idx <= idx;
            rec       <= rdata;
            state     <= ST_SPROC;
          end else begin
            if (s_closed && !have_free) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
            if (idx == LAST_IDX) begin
              state <= ST_SPROC;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_SRD;
            end
          end
        end
        ST_SPROC: begin
          if (p_set) live[p_addr] <= 1'b1;
          if (p_clr) live[p_addr] <= 1'b0;
          res   <= p_res;
          state <= ST_SPUSH;
        end
        ST_SPUSH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_TRD: state <= ST_TCHK;
        ST_TCHK: begin
          if (!stall) begin
            if (retx) begin
              // previous SYN-ACK goes out now that it is known not to be last
              pend_res <= tres;
              pend     <= 1'b1;
              n        <= n + 4'd1;
            end
            if (expire) live[idx] <= 1'b0;
            if (idx == LAST_IDX) begin
              state <= ST_TEND;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_TRD;
            end
          end
        end
        ST_TEND: begin
          if (!pend) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            pend  <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- src/tsct_checker.sv -----
`timescale 1ns / 1ps
module tsct_checker (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input tsct_pkg::result_t  rsp_data
);
  import tsct_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result presented straight after reset");

  a_none: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.code == CODE_NONE |->
      rsp_data.reply == RPL_NONE && rsp_data.last && rsp_data.dest_ip == 32'd0)
    else $error("unprocessed segment carries reply fields");

  a_rst: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.reply == RPL_RSTACK |->
      rsp_data.seq_out == 32'd0 && rsp_data.window_out == 16'd0 && rsp_data.last)
    else $error("malformed RST-ACK");

  a_synack: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.reply == RPL_SYNACK |-> rsp_data.seq_out == ISN &&
      rsp_data.window_out == WINDOW)
    else $error("SYN-ACK with wrong sequence or window");
endmodule

bind tcp_server_connection_table tsct_checker u_tsct_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ----- test/tb_tcp_server_connection_table.sv -----
`timescale 1ns / 1ps
module tb_tcp_server_connection_table;
  import tsct_pkg::*;

  localparam int NSLOT = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_en = 1'b0;
  logic [1:0] cfg_index = CFG_SERVER_PORT;
  logic [31:0] cfg_data = '0;

  tsct_in_if req ();
  tsct_out_if rsp ();

  tcp_server_connection_table u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow copy of the table and registers
  logic [15:0] srv_port;
  logic [31:0] retry_gap;
  logic [3:0]  retry_cap;
  logic [1:0]  tbl_phase [NSLOT];
  logic [31:0] tbl_addr [NSLOT];
  logic [15:0] tbl_port [NSLOT];
  logic [31:0] tbl_own [NSLOT];
  logic [31:0] tbl_pseq [NSLOT];
  logic [31:0] tbl_pack [NSLOT];
  logic [3:0]  tbl_tries [NSLOT];
  logic [31:0] tbl_due [NSLOT];

  item_t   segs_pending [$];
  result_t replies_due [$];
  int errors = 0;
  int n_seg = 0, n_tick = 0, n_res = 0;
  int idle_tx = 0, idle_rx = 0;
  int quiet = 0;

  function automatic void clear_slot(int s);
    tbl_phase[s] = PH_CLOSED; tbl_addr[s] = '0; tbl_port[s] = '0;
    tbl_own[s] = ISN; tbl_pseq[s] = '0; tbl_pack[s] = '0;
    tbl_tries[s] = '0; tbl_due[s] = '0;
  endfunction

  function automatic result_t mk(logic [1:0] c, logic [2:0] r, int s,
                                 logic [31:0] ip, logic [15:0] fp,
                                 logic [15:0] tp, logic [31:0] sq,
                                 logic [31:0] ak, logic [15:0] w);
    result_t x;
    x.code = c; x.reply = r; x.slot_out = s[2:0]; x.dest_ip = ip;
    x.from_port = fp; x.to_port = tp; x.seq_out = sq; x.ack_out = ak;
    x.window_out = w; x.last = 1'b0;
    return x;
  endfunction

  function automatic result_t synack_of(int s);
    return mk(CODE_HANDLED, RPL_SYNACK, s, tbl_addr[s], srv_port, tbl_port[s],
              tbl_own[s], tbl_pseq[s] + 32'd1, WINDOW);
  endfunction

  // established-state handling: FIN, data, or pure ACK
  function automatic result_t est_step(int s, item_t it, logic [31:0] dlen);
    if (it.flags_in[FB_FIN]) begin
      tbl_phase[s] = PH_LASTACK;
      tbl_pseq[s] = it.seq_in;
      return mk(CODE_HANDLED, RPL_FINACK, s, tbl_addr[s], srv_port, tbl_port[s],
                tbl_own[s], it.seq_in + 32'd1, WINDOW);
    end else if (dlen > 0) begin
      tbl_pseq[s] = it.seq_in;
      return mk(CODE_DATA, RPL_ACK, s, tbl_addr[s], srv_port, tbl_port[s],
                tbl_own[s], it.seq_in + dlen, WINDOW);
    end
    if (it.flags_in[FB_ACK]) tbl_pack[s] = it.ack_in;
    return mk(CODE_HANDLED, RPL_NONE, s, 0, 0, 0, 0, 0, 0);
  endfunction

  // works out the results of one item and queues them
  task automatic predict_item(item_t it);
    result_t r;
    int found, s, n;
    logic [31:0] need, dlen;
    found = -1;
    n = 0;
    if (it.kind) begin
      for (s = 0; s < NSLOT; s++) begin
        if (tbl_phase[s] != PH_SYNRCVD || !(it.now > tbl_due[s])) continue;
        if (tbl_tries[s] < retry_cap) begin
          if (n >= MAX_RES) continue;
          tbl_tries[s] = tbl_tries[s] + 4'd1;
          tbl_due[s] = it.now + retry_gap;
          r = synack_of(s);
          replies_due.push_back(r);
          n++;
        end else clear_slot(s);
      end
      if (n > 0) replies_due[$].last = 1'b1;
      return;
    end
    need = 32'(it.ip_hdr_bytes) + 32'(it.header_words) * 4;
    dlen = (32'(it.ip_total) >= need) ? 32'(it.ip_total) - need : 32'd0;
    r = mk(CODE_NONE, RPL_NONE, 0, 0, 0, 0, 0, 0, 0);
    if (it.target_port == srv_port) begin
      for (s = 0; s < NSLOT; s++)
        if (found < 0 && tbl_phase[s] != PH_CLOSED && tbl_addr[s] == it.peer_ip &&
            tbl_port[s] == it.peer_port) found = s;
      if (found < 0) begin
        if (it.flags_in[FB_SYN]) begin
          for (s = 0; s < NSLOT; s++)
            if (found < 0 && tbl_phase[s] == PH_CLOSED) found = s;
          if (found >= 0) begin
            tbl_phase[found] = PH_SYNRCVD; tbl_addr[found] = it.peer_ip;
            tbl_port[found] = it.peer_port; tbl_pseq[found] = it.seq_in;
            tbl_own[found] = ISN; tbl_tries[found] = '0;
            tbl_due[found] = it.now + retry_gap;
            r = synack_of(found);
          end
        end else
          r = mk(CODE_HANDLED, RPL_RSTACK, 0, it.peer_ip, it.target_port,
                 it.peer_port, 0, it.seq_in + 32'd1, 0);
      end else if (it.flags_in[FB_RST]) begin
        clear_slot(found);
        r = mk(CODE_HANDLED, RPL_NONE, found, 0, 0, 0, 0, 0, 0);
      end else begin
        case (tbl_phase[found])
          PH_SYNRCVD: begin
            if (it.flags_in[FB_ACK]) begin
              tbl_phase[found] = PH_EST;
              tbl_own[found] = tbl_own[found] + 32'd1;
              tbl_pack[found] = it.ack_in;
              if (dlen > 0) r = est_step(found, it, dlen);
              else r = mk(CODE_HANDLED, RPL_NONE, found, 0, 0, 0, 0, 0, 0);
            end
          end
          PH_EST: r = est_step(found, it, dlen);
          default: begin
            if (it.flags_in[FB_ACK]) clear_slot(found);
            r = mk(CODE_HANDLED, RPL_NONE, found, 0, 0, 0, 0, 0, 0);
          end
        endcase
      end
    end
    r.last = 1'b1;
    replies_due.push_back(r);
  endtask

  // driver: one item at a time from the pending queue, random gap before each
  initial begin
    req.valid = 1'b0;
    req.data = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      idle_tx <= $urandom_range(0, 7);
    end else if (req.valid && req.ready) begin
      predict_item(req.data);
      if (req.data.kind) n_tick++; else n_seg++;
      if (segs_pending.size() > 0 && idle_tx == 0) begin
        req.data <= segs_pending.pop_front();
        idle_tx <= $urandom_range(0, 7);
      end else req.valid <= 1'b0;
    end else if (!req.valid && segs_pending.size() > 0) begin
      if (idle_tx > 0) idle_tx <= idle_tx - 1;
      else begin
        req.valid <= 1'b1;
        req.data <= segs_pending.pop_front();
        idle_tx <= $urandom_range(0, 7);
      end
    end
  end

  // monitor: random back-pressure, compare every transfer with the oldest due
  initial rsp.ready = 1'b0;

  always @(posedge clk) begin
    result_t got, want;
    if (rst) begin
      rsp.ready <= 1'b0;
      idle_rx <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = rsp.data;
        n_res++;
        if (replies_due.size() == 0) begin
          $error("unexpected result transfer: %p", got);
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (got.code !== want.code) begin
            $error("code exp %0d got %0d", want.code, got.code); errors++; end
          if (got.reply !== want.reply) begin
            $error("reply exp %0d got %0d", want.reply, got.reply); errors++; end
          if (got.slot_out !== want.slot_out) begin
            $error("slot_out exp %0d got %0d", want.slot_out, got.slot_out); errors++; end
          if (got.dest_ip !== want.dest_ip) begin
            $error("dest_ip exp %h got %h", want.dest_ip, got.dest_ip); errors++; end
          if (got.from_port !== want.from_port) begin
            $error("from_port exp %0d got %0d", want.from_port, got.from_port); errors++; end
          if (got.to_port !== want.to_port) begin
            $error("to_port exp %0d got %0d", want.to_port, got.to_port); errors++; end
          if (got.seq_out !== want.seq_out) begin
            $error("seq_out exp %h got %h", want.seq_out, got.seq_out); errors++; end
          if (got.ack_out !== want.ack_out) begin
            $error("ack_out exp %h got %h", want.ack_out, got.ack_out); errors++; end
          if (got.window_out !== want.window_out) begin
            $error("window_out exp %0d got %0d", want.window_out, got.window_out); errors++; end
          if (got.last !== want.last) begin
            $error("last exp %0d got %0d", want.last, got.last); errors++; end
        end
        rsp.ready <= 1'b0;
        idle_rx <= $urandom_range(0, 7);
      end else if (idle_rx > 0) begin
        idle_rx <= idle_rx - 1;
        rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
    end
  end

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT && (segs_pending.size() > 0 || req.valid ||
        replies_due.size() > 0)) begin
      $display("simulation failed");
      $finish;
    end
  end

  // peers used by the random traffic: a handful so that lookups hit
  function automatic item_t seg(logic [31:0] ip, logic [15:0] pp, logic [7:0] fl,
                                logic [31:0] sq, logic [15:0] tot);
    item_t it;
    it = '0;
    it.kind = 1'b0;
    it.now = $urandom();
    it.peer_ip = ip; it.peer_port = pp; it.target_port = srv_port;
    it.seq_in = sq; it.ack_in = $urandom(); it.flags_in = fl;
    it.header_words = 4'd5; it.ip_total = tot; it.ip_hdr_bytes = 6'd20;
    return it;
  endfunction

  function automatic item_t tick_at(logic [31:0] t);
    item_t it;
    it = $bits(item_t)'({7{$urandom()}});
    it.kind = 1'b1;
    it.now = t;
    return it;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_en <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_en <= 1'b0;
    case (idx)
      CFG_SERVER_PORT: srv_port = val[15:0];
      CFG_RETRY_TICKS: retry_gap = val;
      default: retry_cap = val[3:0];
    endcase
  endtask

  // waits for every queued item and every due result, then lets the block settle
  task automatic drain();
    wait (segs_pending.size() == 0 && !req.valid && replies_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    item_t it;
    logic [31:0] clock_now;
    int k, p;
    clock_now = $urandom_range(0, 5000);
    for (k = 0; k < count; k++) begin
      p = $urandom_range(0, 11);
      clock_now = clock_now + $urandom_range(0, 400);
      // well-formed sessions with random content make up most of the traffic
      it = seg(32'hC0A8_0000 | $urandom_range(0, 5), 16'(16'd1000 + $urandom_range(0, 3)),
               8'h10, $urandom(), 16'd40 + 16'($urandom_range(0, 1) * $urandom_range(1, 100)));
      it.now = clock_now;
      case ($urandom_range(0, 9))
        0, 1: it.flags_in = 8'h02;
        2: it.flags_in = 8'h11;
        3: it.flags_in = 8'h04 | 8'($urandom_range(0, 1) << 4);
        4: it.flags_in = 8'($urandom_range(0, 255));
        default: it.flags_in = 8'h10;
      endcase
      if (p == 0) it = tick_at(clock_now);
      else if (p == 1) begin
        it = $bits(item_t)'({7{$urandom()}});
        it.kind = 1'b0;
        if ($urandom_range(0, 1)) it.target_port = srv_port;
        it.ip_hdr_bytes = 6'($urandom_range(0, 60));
      end
      segs_pending.push_back(it);
    end
  endtask

  initial begin
    item_t it;
    int s;
    srv_port = 16'd80; retry_gap = 32'd1000; retry_cap = 4'd3;
    for (s = 0; s < NSLOT; s++) clear_slot(s);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: handshake, data, close, bad port, unknown peer, full table,
    // RST, payload floor, ticks with retransmit and timeout
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h02, 32'hFFFF_FFFF, 16'd40));
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h01, 32'd7, 16'd40));
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h10, 32'd0, 16'd140));
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h18, 32'd100, 16'hFFFF));
    it = seg(32'h0A00_0001, 16'd5000, 8'h10, 32'd200, 16'd0);
    it.header_words = 4'hF; it.ip_hdr_bytes = 6'd60;
    segs_pending.push_back(it);
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h11, 32'hFFFF_FFFF, 16'd40));
    segs_pending.push_back(seg(32'h0A00_0001, 16'd5000, 8'h10, 32'd0, 16'd40));
    it = seg(32'hFFFF_FFFF, 16'hFFFF, 8'h04, 32'hFFFF_FFFF, 16'd40);
    segs_pending.push_back(it);
    it.target_port = 16'd81;
    segs_pending.push_back(it);
    for (s = 0; s < 9; s++)
      segs_pending.push_back(seg(32'h0B00_0000 + s, 16'd0, 8'hFF & ~8'h04, s, 16'd40));
    segs_pending.push_back(seg(32'h0B00_0001, 16'd0, 8'h04, 32'd0, 16'd40));
    segs_pending.push_back(tick_at(32'd0));
    segs_pending.push_back(tick_at(32'hFFFF_FFFF));
    segs_pending.push_back(tick_at(32'hFFFF_FFFF));
    segs_pending.push_back(tick_at(32'hFFFF_FFFF));
    segs_pending.push_back(tick_at(32'hFFFF_FFFF));
    drain();

    // random phases through several register settings, extremes included
    random_phase(110);
    drain();
    write_reg(CFG_SERVER_PORT, 32'd0);
    write_reg(CFG_RETRY_TICKS, 32'd0);
    write_reg(CFG_MAX_RETRIES, 32'd15);
    random_phase(110);
    drain();
    write_reg(CFG_SERVER_PORT, 32'd65535);
    write_reg(CFG_RETRY_TICKS, 32'hFFFF_FFFF);
    write_reg(CFG_MAX_RETRIES, 32'd0);
    random_phase(110);
    drain();
    write_reg(CFG_SERVER_PORT, $urandom_range(0, 65535));
    write_reg(CFG_RETRY_TICKS, $urandom_range(1, 300));
    write_reg(CFG_MAX_RETRIES, $urandom_range(1, 6));
    random_phase(120);
    drain();

    $display("covered %0d segments and %0d ticks, %0d results checked", n_seg, n_tick,
             n_res);
    $display("four register settings, handshakes, data, closes, resets and retries");
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/tsct_pkg.sv
src/tsct_if.sv
src/tsct_ram.sv
src/tcp_server_connection_table.sv
src/tsct_checker.sv
test/tb_tcp_server_connection_table.sv
